/* hdl/rc_pulse_to_rgb_led_drive_unit_defines.svh */
// Assertion macros for the checker file of the LED drive unit.
`ifndef RC_PULSE_TO_RGB_LED_DRIVE_UNIT_DEFINES_SVH
`define RC_PULSE_TO_RGB_LED_DRIVE_UNIT_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define RPL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define RPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/rpl_pkg.sv */
// Shared types, constants and mapping functions of the RC pulse LED drive unit.
package rpl_pkg;

    localparam int TS_W     = 32;
    localparam int WIDTH_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int NUM_CH   = 3;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam int CH_POWER  = 0;
    localparam int CH_COLOR  = 1;
    localparam int CH_BRIGHT = 2;

    // Channels that ignore a falling edge while their stored start is zero.
    localparam logic [NUM_CH-1:0] NEED_START = 3'b110;

    localparam logic [WIDTH_W-1:0] THRESHOLD_RESET = 16'd1500;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX       = 16'hFFFF;
    localparam logic [WIDTH_W-1:0] WIDTH_LOW       = 16'd1000;
    localparam logic [WIDTH_W-1:0] WIDTH_HIGH      = 16'd2000;

    // floor(v / 1000) == (v * RECIP_1000) >> RECIP_SHIFT for every v below 2^18.
    localparam int RECIP_SHIFT = 28;
    localparam logic [18:0] RECIP_1000 = 19'd268436;

    localparam logic [BYTE_W-1:0] HUE_SEG1 = 8'd85;
    localparam logic [BYTE_W-1:0] HUE_SEG2 = 8'd170;
    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

    // Register index codes, taken from the word address.
    localparam logic [0:0] REG_POWER_THRESHOLD = 1'b0;

    typedef struct packed {
        logic [NUM_CH-1:0]               hit;
        logic [NUM_CH-1:0][WIDTH_W-1:0]  width;
    } t_meas;

    typedef struct packed {
        logic              power_led;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] brightness;
    } t_drive;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_rgb;

    // Maps a pulse width of 1000..2000 us onto 0..255, truncating.
    function automatic logic [BYTE_W-1:0] width_to_byte(input logic [WIDTH_W-1:0] w);
        logic [9:0]        d;
        logic [17:0]       v;
        logic [36:0]       p;
        logic [BYTE_W-1:0] q;
        d = 10'(w - WIDTH_LOW);
        v = {d, 8'b0} - {8'b0, d};
        p = 37'(v) * 37'(RECIP_1000);
        if (w < WIDTH_LOW) begin
            q = '0;
        end else if (w >= WIDTH_HIGH) begin
            q = BYTE_MAX;
        end else begin
            q = p[RECIP_SHIFT +: BYTE_W];
        end
        return q;
    endfunction

    // Three-segment color wheel: red to green to blue and back to red.
    function automatic t_rgb color_wheel(input logic [BYTE_W-1:0] h);
        logic [BYTE_W-1:0] d;
        logic [BYTE_W-1:0] up;
        logic [BYTE_W-1:0] down;
        t_rgb              c;
        if (h < HUE_SEG1) begin
            d = h;
        end else if (h < HUE_SEG2) begin
            d = h - HUE_SEG1;
        end else begin
            d = h - HUE_SEG2;
        end
        up   = 8'({d, 1'b0} + 9'(d));
        down = BYTE_MAX - up;
        if (h < HUE_SEG1) begin
            c = '{red: down, green: up, blue: '0};
        end else if (h < HUE_SEG2) begin
            c = '{red: '0, green: down, blue: up};
        end else begin
            c = '{red: up, green: '0, blue: down};
        end
        return c;
    endfunction

endpackage

/* hdl/rpl_pulse_meas.sv */
// Edge detection, pulse start storage and width measurement for the three channels.
module rpl_pulse_meas (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic [rpl_pkg::TS_W-1:0]    i_now,
    input  logic [rpl_pkg::NUM_CH-1:0]  i_levels,
    output rpl_pkg::t_meas              o_meas
);
    import rpl_pkg::*;

    logic [NUM_CH-1:0]            r_prev;
    logic [NUM_CH-1:0][TS_W-1:0]  r_start;
    logic [NUM_CH-1:0][TS_W-1:0]  n_start;
    logic [NUM_CH-1:0][TS_W-1:0]  diff;

    always_comb begin
        o_meas  = '0;
        n_start = r_start;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            diff[ch] = i_now - r_start[ch];
            o_meas.width[ch] = (|diff[ch][TS_W-1:WIDTH_W]) ? WIDTH_MAX
                                                            : diff[ch][WIDTH_W-1:0];
            if (i_levels[ch] && !r_prev[ch]) begin
                n_start[ch] = i_now;
            end else if (!i_levels[ch] && r_prev[ch]) begin
                // A gated channel skips a falling edge that has no recorded start.
                if (!(NEED_START[ch] && (r_start[ch] == '0))) begin
                    o_meas.hit[ch] = 1'b1;
                    n_start[ch]    = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_start <= '0;
        end else if (i_adv) begin
            r_prev  <= i_levels;
            r_start <= n_start;
        end
    end

endmodule

/* hdl/rpl_drive.sv */
// Drive registers: power compare, brightness mapping and color wheel.
module rpl_drive (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  rpl_pkg::t_meas               i_meas,
    input  logic [rpl_pkg::WIDTH_W-1:0]  i_threshold,
    output rpl_pkg::t_drive              o_drive
);
    import rpl_pkg::*;

    t_drive r_drive;
    t_drive n_drive;
    t_rgb   rgb;

    always_comb begin
        n_drive = r_drive;
        rgb     = color_wheel(width_to_byte(i_meas.width[CH_COLOR]));
        if (i_meas.hit[CH_POWER]) begin
            n_drive.power_led = (i_meas.width[CH_POWER] >= i_threshold);
        end
        if (i_meas.hit[CH_COLOR]) begin
            n_drive.red   = rgb.red;
            n_drive.green = rgb.green;
            n_drive.blue  = rgb.blue;
        end
        if (i_meas.hit[CH_BRIGHT]) begin
            n_drive.brightness = width_to_byte(i_meas.width[CH_BRIGHT]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= '0;
        end else if (i_adv) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

/* hdl/rc_pulse_to_rgb_led_drive_unit.sv */
// Top level of the RC pulse width decoder that drives the power, RGB and brightness LEDs.
// A taken input transaction waits in the input stage and moves into the drive registers
// once the result stage is free. One input transaction per cycle while the output does
// not stall; each tick reads and writes the per-channel start registers.
// Reset (synchronous, active low) empties both stages, clears the edge history and
// pulse starts, turns every drive output off and loads the power threshold with 1500.
module rc_pulse_to_rgb_led_drive_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Tick input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rpl_pkg::TS_W-1:0]      i_now_us,
    input  logic                          i_power_level,
    input  logic                          i_color_level,
    input  logic                          i_bright_level,
    // Drive result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_power_led,
    output logic [rpl_pkg::BYTE_W-1:0]    o_red,
    output logic [rpl_pkg::BYTE_W-1:0]    o_green,
    output logic [rpl_pkg::BYTE_W-1:0]    o_blue,
    output logic [rpl_pkg::BYTE_W-1:0]    o_brightness,
    // Register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rpl_pkg::ADDR_W-1:0]    paddr,
    input  logic [rpl_pkg::DATA_W-1:0]    pwdata,
    output logic [rpl_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import rpl_pkg::*;

    // The input stage holds one accepted tick. The drive registers inside
    // rpl_drive double as the result register, so a stalled result keeps its
    // value simply because nothing advances while the output is blocked.
    logic                 r_in_valid;
    logic [TS_W-1:0]      r_now;
    logic [NUM_CH-1:0]    r_levels;
    logic                 r_out_valid;
    logic [WIDTH_W-1:0]   r_threshold;

    logic                 adv;
    logic                 in_take;
    logic                 cfg_write;
    logic [0:0]           reg_idx;
    t_meas                meas;
    t_drive               drive;

    // The held tick moves into the result stage whenever that stage is empty
    // or its transaction leaves in this cycle.
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now    <= i_now_us;
            r_levels <= {i_bright_level, i_color_level, i_power_level};
        end
    end

    // Register port: a single threshold register at word address zero.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1 -: 1];
    assign cfg_write = psel && penable && pwrite && pready
                       && (reg_idx == REG_POWER_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (cfg_write) begin
            r_threshold <= pwdata[WIDTH_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_POWER_THRESHOLD: prdata = DATA_W'(r_threshold);
            default:             prdata = '0;
        endcase
    end

    rpl_pulse_meas u_meas (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_now    (r_now),
        .i_levels (r_levels),
        .o_meas   (meas)
    );

    rpl_drive u_drive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_meas      (meas),
        .i_threshold (r_threshold),
        .o_drive     (drive)
    );

    assign o_out_valid  = r_out_valid;
    assign o_power_led  = drive.power_led;
    assign o_red        = drive.red;
    assign o_green      = drive.green;
    assign o_blue       = drive.blue;
    assign o_brightness = drive.brightness;

endmodule

/* hdl/rpl_checker.sv */
// Port-level assertion checker for the LED drive unit and its bind statement.
`include "rc_pulse_to_rgb_led_drive_unit_defines.svh"

module rpl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_power_led,
    input logic [rpl_pkg::BYTE_W-1:0]  o_red,
    input logic [rpl_pkg::BYTE_W-1:0]  o_green,
    input logic [rpl_pkg::BYTE_W-1:0]  o_blue,
    input logic [rpl_pkg::BYTE_W-1:0]  o_brightness
);

    // The input side only stalls when a finished result is itself held back.
    `RPL_ASSERT(a_stall_only_when_blocked, i_clk, i_rst_n, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled while output free")

    // Reset empties both stages.
    `RPL_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall), "pipeline not empty after reset")

    // A held result keeps its drive values.
    `RPL_ASSERT(a_result_held, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_power_led) && $stable(o_red) && $stable(o_green) && $stable(o_blue) && $stable(o_brightness)), "stalled result changed")

endmodule

bind rc_pulse_to_rgb_led_drive_unit rpl_checker u_rpl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_power_led  (o_power_led),
    .o_red        (o_red),
    .o_green      (o_green),
    .o_blue       (o_blue),
    .o_brightness (o_brightness)
);

/* bench/rc_pulse_to_rgb_led_drive_unit_test.sv */
// Self-checking testbench for the RC pulse width decoder and LED drive unit.
`timescale 1ns / 1ps

module rc_pulse_to_rgb_led_drive_unit_test;
    import rpl_pkg::*;

    // Register addresses. The threshold sits at word 0; word 1 holds no register, so a
    // write there must leave every setting unchanged.
    localparam logic [ADDR_W-1:0] ADDR_POWER_THRESHOLD = {REG_POWER_THRESHOLD, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SPARE           = 3'd4;

    // Channel level patterns, one bit per channel in the order power, color, brightness.
    localparam logic [NUM_CH-1:0] LV_NONE   = 3'b000;
    localparam logic [NUM_CH-1:0] LV_POWER  = 3'b001;
    localparam logic [NUM_CH-1:0] LV_COLOR  = 3'b010;
    localparam logic [NUM_CH-1:0] LV_BRIGHT = 3'b100;
    localparam logic [NUM_CH-1:0] LV_ALL    = 3'b111;

    localparam int IDLE_PERCENT = 13;
    localparam int REPORT_LIMIT = 10;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [TS_W-1:0]     i_now_us;
    logic                i_power_level;
    logic                i_color_level;
    logic                i_bright_level;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_power_led;
    logic [BYTE_W-1:0]   o_red;
    logic [BYTE_W-1:0]   o_green;
    logic [BYTE_W-1:0]   o_blue;
    logic [BYTE_W-1:0]   o_brightness;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Mirror of the decoder state, advanced once for every accepted tick transaction.
    logic [NUM_CH-1:0]   last_levels;
    logic [TS_W-1:0]     pulse_start [NUM_CH];
    logic [WIDTH_W-1:0]  held_width  [NUM_CH];
    logic [WIDTH_W-1:0]  led_threshold;
    t_drive              drive_now;

    // Drive values still owed by the block, oldest first.
    t_drive              drive_queue [$];

    // When set, the sender leaves random gaps and the receiver stalls at random.
    bit                  idle_on;
    int                  error_count;

    // Running microsecond clock that the pulse frames are laid out on.
    logic [TS_W-1:0]     tick_clock;

    rc_pulse_to_rgb_led_drive_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_now_us       (i_now_us),
        .i_power_level  (i_power_level),
        .i_color_level  (i_color_level),
        .i_bright_level (i_bright_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_power_led    (o_power_led),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_brightness   (o_brightness),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 i_clk = ~i_clk;

    // The receiver stalls at random on the falling edge so that stalls land on every
    // phase of the result pipeline.
    always @(negedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    task automatic report_error(input string text);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%0t ERROR: %s", $time, text);
        end
    endtask

    // Maps a latched width of 1000..2000 us onto a duty of 0..255, truncating and
    // clamping at both ends.
    function automatic logic [BYTE_W-1:0] pulse_to_duty(input logic [WIDTH_W-1:0] w);
        int unsigned v;
        if (w < 16'd1000) begin
            return '0;
        end
        v = (32'(w) - 32'd1000) * 32'd255 / 32'd1000;
        return (v > 32'd255) ? 8'd255 : v[BYTE_W-1:0];
    endfunction

    // Three-segment color wheel: red fades to green, green to blue, blue back to red.
    function automatic t_rgb hue_to_rgb(input logic [BYTE_W-1:0] h);
        t_rgb c;
        int   d;
        if (h < 8'd85) begin
            d = 3 * int'(h);
            c.red   = 8'(255 - d);
            c.green = 8'(d);
            c.blue  = '0;
        end else if (h < 8'd170) begin
            d = 3 * (int'(h) - 85);
            c.red   = '0;
            c.green = 8'(255 - d);
            c.blue  = 8'(d);
        end else begin
            d = 3 * (int'(h) - 170);
            c.red   = 8'(d);
            c.green = '0;
            c.blue  = 8'(255 - d);
        end
        return c;
    endfunction

    // Advances the mirrored state by one tick and queues the drive values it leaves.
    // Color and brightness ignore a falling edge while their start is zero; power
    // always measures, so a pulse that rose at timestamp zero gives the timestamp itself.
    task automatic predict_tick(input logic [TS_W-1:0] stamp, input logic [NUM_CH-1:0] lv);
        logic [TS_W-1:0]   span;
        logic [BYTE_W-1:0] duty;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (lv[ch] && !last_levels[ch]) begin
                pulse_start[ch] = stamp;
            end else if (!lv[ch] && last_levels[ch]
                         && !(ch != CH_POWER && pulse_start[ch] == '0)) begin
                span = stamp - pulse_start[ch];
                held_width[ch] = (span > 32'd65535) ? WIDTH_MAX : span[WIDTH_W-1:0];
                pulse_start[ch] = '0;
                duty = pulse_to_duty(held_width[ch]);
                if (ch == CH_POWER) begin
                    drive_now.power_led = (held_width[ch] >= led_threshold);
                end else if (ch == CH_COLOR) begin
                    {drive_now.red, drive_now.green, drive_now.blue} = hue_to_rgb(duty);
                end else begin
                    drive_now.brightness = duty;
                end
            end
        end
        last_levels = lv;
        drive_queue.push_back(drive_now);
    endtask

    // Offers one tick transaction on the falling edge, optionally after a few idle
    // cycles, and holds it until the block takes it at a rising edge without stall.
    task automatic send_tick(input logic [TS_W-1:0] stamp, input logic [NUM_CH-1:0] lv);
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_now_us       <= stamp;
        i_power_level  <= lv[CH_POWER];
        i_color_level  <= lv[CH_COLOR];
        i_bright_level <= lv[CH_BRIGHT];
        do @(posedge i_clk); while (o_in_stall);
        predict_tick(stamp, lv);
    endtask

    // Stops offering ticks and waits until every queued drive value has been seen.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (drive_queue.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes one register while the block is idle, then reads the threshold back.
    task automatic program_register(input logic [ADDR_W-1:0] addr,
                                    input logic [DATA_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_POWER_THRESHOLD) begin
            led_threshold = data[WIDTH_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= ADDR_POWER_THRESHOLD;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{(DATA_W-WIDTH_W){1'b0}}, led_threshold}) begin
            report_error($sformatf("threshold readback: expected %0d, got %0d",
                                   led_threshold, prdata));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One frame of receiver pulses with random widths and offsets, sampled at random
    // intervals. Most widths sit in the servo range; a few are short or very long so
    // that clamping and saturation are reached. The frame ends with every channel low.
    task automatic send_pulse_frame();
        int unsigned rise [NUM_CH];
        int unsigned fall [NUM_CH];
        int unsigned wid;
        int unsigned span;
        int unsigned step_max;
        int unsigned t;
        int          kind;
        logic [NUM_CH-1:0] lv;
        if ($urandom_range(0, 19) == 0) begin
            tick_clock = $urandom();
        end
        span = 0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                wid = $urandom_range(0, 999);
            end else if (kind == 1) begin
                wid = $urandom_range(2001, 200000);
            end else begin
                wid = $urandom_range(900, 2100);
            end
            rise[ch] = $urandom_range(0, 300);
            fall[ch] = rise[ch] + wid;
            if (fall[ch] > span) begin
                span = fall[ch];
            end
        end
        span += $urandom_range(1, 300);
        step_max = span / 12 + 1;
        t = 0;
        while (t < span) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                lv[ch] = (t >= rise[ch]) && (t < fall[ch]);
            end
            send_tick(tick_clock + 32'(t), lv);
            t += $urandom_range(1, step_max);
        end
        send_tick(tick_clock + 32'(span), LV_NONE);
        tick_clock += 32'(span) + 32'd1;
    endtask

    // Directed ticks from reset: steady levels, each channel's edges, the hue segment
    // boundaries, clamping at both ends, pulses that start at timestamp zero, a
    // saturated width, a timestamp wrap and all three channels falling together.
    task automatic test_reset_and_edges();
        send_tick(32'd5,          LV_NONE);
        send_tick(32'd100,        LV_POWER);
        send_tick(32'd1600,       LV_NONE);
        send_tick(32'd2000,       LV_COLOR);
        send_tick(32'd3000,       LV_NONE);
        send_tick(32'd3100,       LV_COLOR);
        send_tick(32'd4434,       LV_NONE);
        send_tick(32'd5000,       LV_COLOR);
        send_tick(32'd6667,       LV_NONE);
        send_tick(32'd7000,       LV_COLOR | LV_BRIGHT);
        send_tick(32'd9500,       LV_NONE);
        send_tick(32'd10000,      LV_BRIGHT);
        send_tick(32'd10999,      LV_NONE);
        send_tick(32'd11000,      LV_POWER);
        send_tick(32'd12499,      LV_NONE);
        // Color and brightness pulses that rise at timestamp zero are never measured.
        send_tick(32'd0,          LV_COLOR);
        send_tick(32'd1500,       LV_COLOR);
        send_tick(32'd1800,       LV_NONE);
        send_tick(32'd0,          LV_BRIGHT);
        send_tick(32'd1200,       LV_NONE);
        // A power pulse from timestamp zero is measured and saturates here.
        send_tick(32'd0,          LV_POWER);
        send_tick(32'd70000,      LV_NONE);
        send_tick(32'hFFFF_FF00,  LV_POWER | LV_COLOR);
        send_tick(32'h0000_0400,  LV_NONE);
        send_tick(32'hFFFF_FFFF,  LV_ALL);
        send_tick(32'd1499,       LV_NONE);
    endtask

    // Threshold extremes, a write to the unmapped word and upper data bits that the
    // 16-bit register must drop.
    task automatic test_register_port();
        program_register(ADDR_POWER_THRESHOLD, 32'd0);
        send_tick(32'd100,   LV_POWER);
        send_tick(32'd100,   LV_NONE);
        program_register(ADDR_POWER_THRESHOLD, 32'd65535);
        send_tick(32'd200,   LV_POWER);
        send_tick(32'd65734, LV_NONE);
        send_tick(32'd300,   LV_POWER);
        send_tick(32'd80000, LV_NONE);
        program_register(ADDR_SPARE, 32'd0);
        send_tick(32'd400,   LV_POWER);
        send_tick(32'd65934, LV_NONE);
        program_register(ADDR_POWER_THRESHOLD, 32'hABCD_05DC);
        send_tick(32'd500,   LV_POWER);
        send_tick(32'd2000,  LV_NONE);
    endtask

    // Random pulse frames under a run of threshold settings, extremes included.
    task automatic test_pulse_frames();
        logic [WIDTH_W-1:0] setting [5];
        setting = '{16'($urandom_range(0, 65535)), 16'd0, 16'hFFFF,
                    16'($urandom_range(900, 2100)), THRESHOLD_RESET};
        foreach (setting[i]) begin
            program_register(ADDR_POWER_THRESHOLD, {16'h0, setting[i]});
            repeat (6) send_pulse_frame();
        end
    endtask

    // Frames with neither sender gaps nor receiver stalls, so the block runs flat out.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (12) send_pulse_frame();
        idle_on = 1'b1;
    endtask

    // Unstructured ticks: random timestamps and random levels on every channel.
    task automatic test_line_noise();
        repeat (150) begin
            send_tick($urandom(), 3'($urandom_range(0, 7)));
        end
    endtask

    // Every result transaction is compared against the oldest expected drive value.
    always @(posedge i_clk) begin : check_results
        t_drive want;
        t_drive got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{power_led: o_power_led, red: o_red, green: o_green, blue: o_blue,
                    brightness: o_brightness};
            if (drive_queue.size() == 0) begin
                report_error($sformatf("result with nothing expected: pwr=%0b r=%0d g=%0d b=%0d br=%0d",
                             got.power_led, got.red, got.green, got.blue, got.brightness));
            end else begin
                want = drive_queue.pop_front();
                if (got !== want) begin
                    report_error($sformatf({"drive mismatch: expected pwr=%0b r=%0d g=%0d b=%0d ",
                                            "br=%0d, got pwr=%0b r=%0d g=%0d b=%0d br=%0d"},
                                 want.power_led, want.red, want.green, want.blue,
                                 want.brightness, got.power_led, got.red, got.green,
                                 got.blue, got.brightness));
                end
            end
        end
    end

    // The run is bounded by a generous fixed time in case the handshake hangs.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_now_us       = '0;
        i_power_level  = 1'b0;
        i_color_level  = 1'b0;
        i_bright_level = 1'b0;
        i_out_stall    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        idle_on        = 1'b1;
        error_count    = 0;
        tick_clock     = 32'd1000;
        last_levels    = '0;
        led_threshold  = THRESHOLD_RESET;
        drive_now      = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            pulse_start[ch] = '0;
            held_width[ch]  = THRESHOLD_RESET;
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_and_edges();
        test_register_port();
        test_pulse_frames();
        test_back_to_back();
        test_line_noise();

        // Let the pipeline settle after the last expected result so that any stray result
        // transaction is caught before the verdict.
        drain_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && drive_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
